### hdl/pbrm_pkg.sv
// Package for the page bitmap region marker: map geometry, field widths,
// request codes and controller states. No dependencies.
package pbrm_pkg;

  // Map geometry (page and word sizes are powers of two)
  localparam int unsigned PageBytes = 4096;
  localparam int unsigned MapPages  = 65536;
  localparam int unsigned WordBits  = 64;

  localparam int unsigned PageShift = $clog2(PageBytes);
  localparam int unsigned WordShift = $clog2(WordBits);
  localparam int unsigned MapWords  = (MapPages + WordBits - 1) / WordBits;
  localparam int unsigned WordAw    = (MapWords > 1) ? $clog2(MapWords) : 1;

  // Field widths
  localparam int unsigned AddrW    = 48;
  localparam int unsigned EndW     = AddrW + 1;
  localparam int unsigned BasePgW  = AddrW - PageShift;
  localparam int unsigned PageNumW = EndW - PageShift;
  localparam int unsigned CountW   = $clog2(MapPages + 1);
  localparam int unsigned FirstW   = 36;
  localparam int unsigned MarkedW  = 17;
  localparam int unsigned QueryW   = 16;

  // Request codes
  typedef enum logic [1:0] {
    REQ_MARK_ALL = 2'd0,
    REQ_FREE     = 2'd1,
    REQ_QUERY    = 2'd2,
    REQ_NONE     = 2'd3
  } req_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_PAGES,
    ST_SPAN,
    ST_READ,
    ST_WRITE,
    ST_QREAD,
    ST_QBIT
  } state_e;

endpackage

### hdl/pbrm_ram.sv
// Generic single-clock RAM: one write port, one read port with registered data.
// No dependencies.
module pbrm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/page_bitmap_region_marker.sv
// Top level of the page bitmap region marker: controller and datapath around
// the bitmap RAM. Depends on pbrm_pkg and pbrm_ram.

// One bit per physical page (1 used, 0 free) lives in a 1024 x 64 RAM. After
// reset the block runs a clearing pass that writes every bitmap word to all
// ones, with busy_o high. A request is taken when start_i is high and busy_o
// low. Mark-all repeats that pass, then reports. A free-region request turns
// the byte range into a page span (ST_PAGES, ST_SPAN), then reads each bitmap
// word touched and writes it back masked through the single RAM port pair
// (ST_READ, ST_WRITE); it ends at ST_SPAN when skipped or wholly beyond the
// map. A query reads the page's word (ST_QREAD), then picks its bit (ST_QBIT);
// an unknown request is answered from ST_IDLE. Every result shows on the
// result ports for exactly one cycle with done_o high and must be taken then:
// nothing holds it. busy_o drops in the cycle done_o is high.
module page_bitmap_region_marker
  import pbrm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [1:0]            req_type_i,
  input  logic [AddrW-1:0]      region_base_i,
  input  logic [AddrW-1:0]      region_length_i,
  input  logic                  final_region_i,
  input  logic [QueryW-1:0]     query_page_i,
  output logic                  done_o,
  output logic                  status_o,
  output logic [FirstW-1:0]     first_page_o,
  output logic [MarkedW-1:0]    pages_marked_o,
  output logic                  page_used_o,
  output logic                  map_ready_o
);

  // Control registers
  state_e              state_q, state_d;
  logic                ready_q, ready_d;
  logic                reply_q, reply_d;
  logic                done_q, done_d;
  logic [WordAw-1:0]   word_q, word_d;

  // Request and datapath registers
  logic [AddrW-1:0]    base_q, base_d;
  logic [AddrW-1:0]    len_q, len_d;
  logic                final_q, final_d;
  logic [QueryW-1:0]   qpage_q, qpage_d;
  logic [PageNumW-1:0] endpg_q, endpg_d;
  logic [PageNumW-1:0] pfirst_q, pfirst_d;
  logic [WordAw-1:0]   first_word_q, first_word_d;
  logic [WordAw-1:0]   last_word_q, last_word_d;
  logic [WordShift-1:0] lo_bit_q, lo_bit_d;
  logic [WordShift-1:0] hi_bit_q, hi_bit_d;

  // Result registers
  logic                status_q, status_d;
  logic [FirstW-1:0]   first_page_q, first_page_d;
  logic [MarkedW-1:0]  marked_q, marked_d;
  logic                used_q, used_d;

  // RAM port signals
  logic                ram_we, ram_re;
  logic [WordAw-1:0]   ram_waddr, ram_raddr;
  logic [WordBits-1:0] ram_wdata, ram_rdata;

  // Span arithmetic
  logic [EndW-1:0]     end_byte;
  logic [BasePgW-1:0]  base_pg;
  logic                round_up;
  logic                span_skip;
  logic                span_in_map;
  logic [CountW-1:0]   stop_pg;
  logic [CountW-1:0]   start_pg;
  logic [CountW-1:0]   stop_m1;
  logic [CountW-1:0]   span_count;

  // Word mask and query selection
  logic [WordShift-1:0] mask_lo, mask_hi;
  logic [WordBits-1:0]  clear_mask;
  logic [31:0]          qpage_ext;
  logic                 query_out;

  pbrm_ram #(
    .Width (WordBits),
    .Depth (1 << WordAw)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Byte range to page numbers: end page, and start page rounded up past page zero
  always_comb begin
    end_byte = {1'b0, base_q} + {1'b0, len_q};
    base_pg  = base_q[AddrW-1:PageShift];
    round_up = (|base_q[PageShift-1:0]) | (base_pg == '0);
  end

  // Clip span at the map end and count pages inside the map
  always_comb begin
    span_skip   = (endpg_q <= pfirst_q);
    span_in_map = (pfirst_q < PageNumW'(MapPages));
    if (endpg_q > PageNumW'(MapPages)) begin
      stop_pg = CountW'(MapPages);
    end else begin
      stop_pg = endpg_q[CountW-1:0];
    end
    start_pg   = pfirst_q[CountW-1:0];
    stop_m1    = stop_pg - CountW'(1);
    span_count = stop_pg - start_pg;
  end

  // Build the clear mask for the current word
  always_comb begin
    mask_lo    = (word_q == first_word_q) ? lo_bit_q : '0;
    mask_hi    = (word_q == last_word_q) ? hi_bit_q : '1;
    clear_mask = ({WordBits{1'b1}} << mask_lo) & ({WordBits{1'b1}} >> (~mask_hi));
  end

  // Query page address split
  always_comb begin
    qpage_ext = 32'(qpage_q);
    query_out = (qpage_ext >= 32'(MapPages));
  end

  // Next state, datapath and RAM control
  always_comb begin
    state_d      = state_q;
    ready_d      = ready_q;
    reply_d      = reply_q;
    done_d       = 1'b0;
    word_d       = word_q;
    base_d       = base_q;
    len_d        = len_q;
    final_d      = final_q;
    qpage_d      = qpage_q;
    endpg_d      = endpg_q;
    pfirst_d     = pfirst_q;
    first_word_d = first_word_q;
    last_word_d  = last_word_q;
    lo_bit_d     = lo_bit_q;
    hi_bit_d     = hi_bit_q;
    status_d     = status_q;
    first_page_d = first_page_q;
    marked_d     = marked_q;
    used_d       = used_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = word_q;
    ram_raddr    = word_q;
    ram_wdata    = ram_rdata & ~clear_mask;

    unique case (state_q)
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = '1;
        if (word_q == WordAw'(MapWords - 1)) begin
          state_d = ST_IDLE;
          if (reply_q) begin
            reply_d      = 1'b0;
            done_d       = 1'b1;
            status_d     = 1'b0;
            first_page_d = '0;
            marked_d     = '0;
            used_d       = 1'b0;
          end
        end else begin
          word_d = word_q + WordAw'(1);
        end
      end

      ST_IDLE: begin
        if (start_i) begin
          base_d  = region_base_i;
          len_d   = region_length_i;
          final_d = final_region_i;
          qpage_d = query_page_i;
          unique case (req_e'(req_type_i))
            REQ_MARK_ALL: begin
              word_d  = '0;
              reply_d = 1'b1;
              ready_d = 1'b0;
              state_d = ST_FILL;
            end
            REQ_FREE: begin
              state_d = ST_PAGES;
            end
            REQ_QUERY: begin
              state_d = ST_QREAD;
            end
            default: begin
              done_d       = 1'b1;
              status_d     = 1'b0;
              first_page_d = '0;
              marked_d     = '0;
              used_d       = 1'b0;
            end
          endcase
        end
      end

      ST_PAGES: begin
        endpg_d  = end_byte[EndW-1:PageShift];
        pfirst_d = PageNumW'(base_pg) + PageNumW'(round_up);
        state_d  = ST_SPAN;
      end

      ST_SPAN: begin
        used_d = 1'b0;
        if (final_q) begin
          ready_d = 1'b1;
        end
        if (span_skip) begin
          done_d       = 1'b1;
          status_d     = 1'b1;
          first_page_d = '0;
          marked_d     = '0;
          state_d      = ST_IDLE;
        end else begin
          status_d     = 1'b0;
          first_page_d = FirstW'(pfirst_q);
          if (span_in_map) begin
            marked_d     = MarkedW'(span_count);
            word_d       = WordAw'(start_pg >> WordShift);
            first_word_d = WordAw'(start_pg >> WordShift);
            last_word_d  = WordAw'(stop_m1 >> WordShift);
            lo_bit_d     = start_pg[WordShift-1:0];
            hi_bit_d     = stop_m1[WordShift-1:0];
            state_d      = ST_READ;
          end else begin
            done_d   = 1'b1;
            marked_d = '0;
            state_d  = ST_IDLE;
          end
        end
      end

      ST_READ: begin
        ram_re  = 1'b1;
        state_d = ST_WRITE;
      end

      ST_WRITE: begin
        ram_we = 1'b1;
        if (word_q == last_word_q) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          word_d  = word_q + WordAw'(1);
          state_d = ST_READ;
        end
      end

      ST_QREAD: begin
        ram_re    = 1'b1;
        ram_raddr = qpage_ext[WordShift +: WordAw];
        state_d   = ST_QBIT;
      end

      ST_QBIT: begin
        done_d       = 1'b1;
        status_d     = 1'b0;
        first_page_d = '0;
        marked_d     = '0;
        used_d       = query_out | ram_rdata[qpage_ext[WordShift-1:0]];
        state_d      = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers: start with the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
      ready_q <= 1'b0;
      reply_q <= 1'b0;
      done_q  <= 1'b0;
      word_q  <= '0;
    end else begin
      state_q <= state_d;
      ready_q <= ready_d;
      reply_q <= reply_d;
      done_q  <= done_d;
      word_q  <= word_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    base_q       <= base_d;
    len_q        <= len_d;
    final_q      <= final_d;
    qpage_q      <= qpage_d;
    endpg_q      <= endpg_d;
    pfirst_q     <= pfirst_d;
    first_word_q <= first_word_d;
    last_word_q  <= last_word_d;
    lo_bit_q     <= lo_bit_d;
    hi_bit_q     <= hi_bit_d;
    status_q     <= status_d;
    first_page_q <= first_page_d;
    marked_q     <= marked_d;
    used_q       <= used_d;
  end

  // Drive outputs
  assign busy_o         = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign first_page_o   = first_page_q;
  assign pages_marked_o = marked_q;
  assign page_used_o    = used_q;
  assign map_ready_o    = ready_q;

endmodule
